FILE: sv/nra_pkg.sv
// ----------------------------------------------------------------------------
// nra_pkg: shared types and constants for the Newton root attractor
// Register map, outcome codes, accumulator op codes and the elaboration-time
// generator of the root-of-unity table.
// ----------------------------------------------------------------------------
package nra_pkg;

    // register indexes (byte address / 4)
    localparam logic [1:0] REG_DEGREE   = 2'd0;
    localparam logic [1:0] REG_ESC_LIM  = 2'd1;
    localparam logic [1:0] REG_ITER_CAP = 2'd2;

    // register reset values
    localparam logic [3:0] DEGREE_RST   = 4'd3;
    localparam logic [6:0] ESC_LIM_RST  = 7'd127;
    localparam logic [6:0] ITER_CAP_RST = 7'd127;

    // outcome codes
    localparam logic [1:0] OUT_CONVERGED = 2'd0;
    localparam logic [1:0] OUT_NEAR_ZERO = 2'd1;
    localparam logic [1:0] OUT_ESCAPED   = 2'd2;
    localparam logic [1:0] OUT_CAP_HIT   = 2'd3;

    // accumulator operations
    typedef logic [1:0] mac_op_t;
    localparam mac_op_t MAC_NONE = 2'd0;
    localparam mac_op_t MAC_LOAD = 2'd1;
    localparam mac_op_t MAC_ADD  = 2'd2;
    localparam mac_op_t MAC_SUB  = 2'd3;

    // symmetric saturation bound
    localparam logic signed [31:0] SAT_MAX = 32'sd2147483647;

    // Q2.30 constants for the root generator
    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
    localparam longint          ONE_Q30     = 64'sd1073741824;

    // configuration register set
    typedef struct packed {
        logic [3:0] degree;
        logic [6:0] esc_limit;
        logic [6:0] iter_cap;
    } nra_cfg_t;

    // restoring divide, only evaluated on constants
    function automatic longint unsigned udiv64(longint unsigned a, longint unsigned b);
        longint unsigned q;
        longint unsigned r;
        q = 64'd0;
        r = 64'd0;
        for (int i = 63; i >= 0; i--)
        begin
            r = {r[62:0], a[i]};
            q = q << 1;
            if (r >= b)
            begin
                r = r - b;
                q[0] = 1'b1;
            end
        end
        return q;
    endfunction

    // clamp to [0,1] in Q2.30 and round to frac bits
    function automatic longint round_from_q30(longint v, int unsigned frac);
        longint t;
        int unsigned sh;
        sh = 30 - frac;
        t = v;
        if (t < 0)
            t = 0;
        if (t > ONE_Q30)
            t = ONE_Q30;
        return (t + (longint'(1) << (sh - 1))) >>> sh;
    endfunction

    // root k of z^d - 1 as {re, im}, Taylor series over one quadrant
    function automatic logic [63:0] make_root(int unsigned k, int unsigned d,
                                              int unsigned frac);
        longint unsigned quad;
        longint unsigned r;
        longint unsigned x;
        longint unsigned term;
        longint c;
        longint s;
        longint cr;
        longint ci;
        quad = udiv64(longint'(4 * k), longint'(d));
        r    = longint'(4 * k) - quad * longint'(d);
        x    = udiv64(HALF_PI_Q30 * r + longint'(d >> 1), longint'(d));
        term = longint'(ONE_Q30);
        c    = 0;
        s    = 0;
        for (int n = 0; n < 24; n++)
        begin
            case (n & 3)
                0: c = c + longint'(term);
                1: s = s + longint'(term);
                2: c = c - longint'(term);
                default: s = s - longint'(term);
            endcase
            term = udiv64((term * x) >> 30, longint'(n + 1));
        end
        c = round_from_q30(c, frac);
        s = round_from_q30(s, frac);
        case (quad[1:0])
            2'd0:
            begin
                cr = c;
                ci = s;
            end
            2'd1:
            begin
                cr = -s;
                ci = c;
            end
            2'd2:
            begin
                cr = -c;
                ci = -s;
            end
            default:
            begin
                cr = s;
                ci = -c;
            end
        endcase
        return {cr[31:0], ci[31:0]};
    endfunction

endpackage

FILE: sv/nra_in_if.sv
// ----------------------------------------------------------------------------
// nra_in_if: start point channel
// Valid/ready channel carrying one complex start point in signed fixed point.
// ----------------------------------------------------------------------------
interface nra_in_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] start_real;
    logic signed [31:0] start_imag;

    modport source (output valid, output start_real, output start_imag, input ready);
    modport sink   (input valid, input start_real, input start_imag, output ready);
endinterface

FILE: sv/nra_out_if.sv
// ----------------------------------------------------------------------------
// nra_out_if: result channel
// Valid/ready channel carrying outcome, root index and step count of a point.
// ----------------------------------------------------------------------------
interface nra_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] outcome;
    logic [3:0] root_index;
    logic [6:0] iteration_count;

    modport source (output valid, output outcome, output root_index,
                    output iteration_count, input ready);
    modport sink   (input valid, input outcome, input root_index,
                    input iteration_count, output ready);
endinterface

FILE: sv/nra_cfg.sv
// ----------------------------------------------------------------------------
// nra_cfg: configuration registers
// APB-style register file for degree, escape limit and iteration cap.
// ----------------------------------------------------------------------------
module nra_cfg
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [3:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready,
    output nra_pkg::nra_cfg_t    cfg
);

    nra_pkg::nra_cfg_t cfg_reg;
    nra_pkg::nra_cfg_t cfg_next;
    logic              wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign cfg    = cfg_reg;

    // register write decode
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (paddr[3:2])
                nra_pkg::REG_DEGREE:   cfg_next.degree    = pwdata[3:0];
                nra_pkg::REG_ESC_LIM:  cfg_next.esc_limit = pwdata[6:0];
                nra_pkg::REG_ITER_CAP: cfg_next.iter_cap  = pwdata[6:0];
                default:               cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.degree    <= nra_pkg::DEGREE_RST;
            cfg_reg.esc_limit <= nra_pkg::ESC_LIM_RST;
            cfg_reg.iter_cap  <= nra_pkg::ITER_CAP_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // read mux
    always_comb
    begin
        case (paddr[3:2])
            nra_pkg::REG_DEGREE:   prdata = {28'd0, cfg_reg.degree};
            nra_pkg::REG_ESC_LIM:  prdata = {25'd0, cfg_reg.esc_limit};
            nra_pkg::REG_ITER_CAP: prdata = {25'd0, cfg_reg.iter_cap};
            default:               prdata = 32'd0;
        endcase
    end

endmodule

FILE: sv/nra_mac.sv
// ----------------------------------------------------------------------------
// nra_mac: shared multiply-accumulate unit
// Registered 33x33 signed multiplier followed by a 67-bit accumulator.
// ----------------------------------------------------------------------------
module nra_mac
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic signed [32:0]   op_a,
    input  logic signed [32:0]   op_b,
    input  nra_pkg::mac_op_t     op,
    output logic signed [65:0]   prod,
    output logic signed [66:0]   acc
);

    logic signed [65:0] prod_reg;
    logic signed [66:0] acc_reg;
    logic signed [66:0] acc_next;
    nra_pkg::mac_op_t   op_reg;

    assign prod = prod_reg;
    assign acc  = acc_reg;

    // product stage
    always_ff @(posedge clk)
    begin
        prod_reg <= op_a * op_b;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            op_reg <= nra_pkg::MAC_NONE;
        else
            op_reg <= op;
    end

    // accumulate stage, registered in the cycle after the product
    always_comb
    begin
        case (op_reg)
            nra_pkg::MAC_LOAD: acc_next = {prod_reg[65], prod_reg};
            nra_pkg::MAC_ADD:  acc_next = acc_reg + {prod_reg[65], prod_reg};
            nra_pkg::MAC_SUB:  acc_next = acc_reg - {prod_reg[65], prod_reg};
            default:           acc_next = acc_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
    end

endmodule

FILE: sv/nra_div.sv
// ----------------------------------------------------------------------------
// nra_div: fixed-point quotient unit
// Signed num * 2^F / den, truncated toward zero, saturated to +-(2^31-1);
// one quotient bit per cycle by restoring division.
// ----------------------------------------------------------------------------
module nra_div
#(
    parameter int FRAC_BITS = 24
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic signed [63:0]   num,
    input  logic [63:0]          den,
    output logic                 done,
    output logic signed [31:0]   quo
);

    localparam int SH = 31 - FRAC_BITS;

    logic               busy_reg;
    logic               busy_next;
    logic               done_reg;
    logic               done_next;
    logic [4:0]         cnt_reg;
    logic [4:0]         cnt_next;
    logic [63:0]        rem_reg;
    logic [63:0]        rem_next;
    logic [30:0]        sh_reg;
    logic [30:0]        sh_next;
    logic [30:0]        q_reg;
    logic [30:0]        q_next;
    logic               neg_reg;
    logic               neg_next;
    logic signed [31:0] quo_reg;
    logic signed [31:0] quo_next;

    logic [63:0]        mag;
    logic [63+SH:0]     den_wide;
    logic [63+SH:0]     mag_wide;
    logic [63+FRAC_BITS:0] mag_frac;
    logic [63:0]        rem_sh;
    logic [30:0]        q_step;

    assign done = done_reg;
    assign quo  = quo_reg;

    // operand magnitude and overflow test
    assign mag      = num[63] ? 64'(-num) : 64'(num);
    assign den_wide = {den, {SH{1'b0}}};
    assign mag_wide = {{SH{1'b0}}, mag};
    assign mag_frac = {mag, {FRAC_BITS{1'b0}}};
    assign rem_sh   = {rem_reg[62:0], sh_reg[30]};
    assign q_step   = {q_reg[29:0], (rem_sh >= den)};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        sh_next   = sh_reg;
        q_next    = q_reg;
        neg_next  = neg_reg;
        quo_next  = quo_reg;
        if (start)
        begin
            neg_next = num[63];
            if (den == 64'd0)
            begin
                done_next = 1'b1;
                if (num == 64'sd0)
                    quo_next = 32'sd0;
                else if (num[63])
                    quo_next = -nra_pkg::SAT_MAX;
                else
                    quo_next = nra_pkg::SAT_MAX;
            end
            else if (mag_wide >= den_wide)
            begin
                done_next = 1'b1;
                quo_next  = num[63] ? -nra_pkg::SAT_MAX : nra_pkg::SAT_MAX;
            end
            else
            begin
                busy_next = 1'b1;
                cnt_next  = 5'd0;
                rem_next  = mag >> SH;
                sh_next   = mag_frac[30:0];
                q_next    = 31'd0;
            end
        end
        else if (busy_reg)
        begin
            // one restoring step
            rem_next = (rem_sh >= den) ? rem_sh - den : rem_sh;
            sh_next  = {sh_reg[29:0], 1'b0};
            q_next   = q_step;
            cnt_next = cnt_reg + 5'd1;
            if (cnt_reg == 5'd30)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
                quo_next  = neg_reg ? -$signed({1'b0, q_step}) : $signed({1'b0, q_step});
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 5'd0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        sh_reg  <= sh_next;
        q_reg   <= q_next;
        neg_reg <= neg_next;
        quo_reg <= quo_next;
    end

endmodule

FILE: sv/newton_root_attractor.sv
// ----------------------------------------------------------------------------
// newton_root_attractor: Newton iteration for z^d - 1 on one complex point
// Sequencer over a shared multiply-accumulate unit and a serial divider.
// ----------------------------------------------------------------------------
// One point is taken at a time and its result comes out on the result channel;
// the next point is accepted while that result waits. Each Newton step runs
// the near-zero and escape checks, the convergence test against each root,
// one complex product per degree for the power z^d on the shared 33x33
// multiplier, the derivative, denominator and numerators, two passes of the
// one-bit-per-cycle divider, which dominates, and the step count advance.
// A point takes up to min(iteration_cap, MAX_ITER) steps, besides its entry
// and exit. The root table is constant and needs no time after reset.
module newton_root_attractor
#(
    parameter int MAX_DEGREE = 10,
    parameter int MAX_ITER   = 127,
    parameter int FRAC_BITS  = 24
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [3:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready,
    nra_in_if.sink       item_in,
    nra_out_if.source    result_out
);

    localparam int ROM_DEPTH = MAX_DEGREE * (MAX_DEGREE + 1) / 2;
    localparam int RW        = (ROM_DEPTH > 1) ? $clog2(ROM_DEPTH) : 1;
    localparam int DW        = $clog2(MAX_DEGREE + 1);
    localparam int IW        = $clog2(MAX_ITER + 1);
    localparam int LIM_W     = 7 + FRAC_BITS;
    localparam int CMP_W     = (LIM_W > 33) ? LIM_W : 33;
    localparam logic [66:0]        THR      = 67'((64'd1 << (2 * FRAC_BITS)) / 64'd1000000);
    localparam logic signed [66:0] HALF_LSB = 67'sd1 <<< (FRAC_BITS - 1);
    localparam logic signed [66:0] SAT_HI   = 67'sd2147483647;
    localparam logic signed [31:0] ONE_Q    = 32'sd1 <<< FRAC_BITS;

    // sequencer states
    localparam logic [5:0] S_IDLE = 6'd0;
    localparam logic [5:0] S_CHK  = 6'd1;
    localparam logic [5:0] S_NZ1  = 6'd2;
    localparam logic [5:0] S_NZ2  = 6'd3;
    localparam logic [5:0] S_NZ3  = 6'd4;
    localparam logic [5:0] S_CV0  = 6'd5;
    localparam logic [5:0] S_CV1  = 6'd6;
    localparam logic [5:0] S_CV2  = 6'd7;
    localparam logic [5:0] S_CV3  = 6'd8;
    localparam logic [5:0] S_PW0  = 6'd9;
    localparam logic [5:0] S_PW1  = 6'd10;
    localparam logic [5:0] S_PW2  = 6'd11;
    localparam logic [5:0] S_PW3  = 6'd12;
    localparam logic [5:0] S_PW4  = 6'd13;
    localparam logic [5:0] S_PW5  = 6'd14;
    localparam logic [5:0] S_DR0  = 6'd15;
    localparam logic [5:0] S_DR1  = 6'd16;
    localparam logic [5:0] S_DR2  = 6'd17;
    localparam logic [5:0] S_DN0  = 6'd18;
    localparam logic [5:0] S_DN1  = 6'd19;
    localparam logic [5:0] S_DN2  = 6'd20;
    localparam logic [5:0] S_DN3  = 6'd21;
    localparam logic [5:0] S_DN4  = 6'd22;
    localparam logic [5:0] S_DN5  = 6'd23;
    localparam logic [5:0] S_DN6  = 6'd24;
    localparam logic [5:0] S_DN7  = 6'd25;
    localparam logic [5:0] S_DN8  = 6'd26;
    localparam logic [5:0] S_DVR  = 6'd27;
    localparam logic [5:0] S_DVRW = 6'd28;
    localparam logic [5:0] S_DVI  = 6'd29;
    localparam logic [5:0] S_DVIW = 6'd30;
    localparam logic [5:0] S_UPD  = 6'd31;
    localparam logic [5:0] S_FIN  = 6'd32;

    nra_pkg::nra_cfg_t cfg;

    // constant root table, {re, im} per entry
    logic [63:0] root_tab [ROM_DEPTH];

    for (genvar gd = 1; gd <= MAX_DEGREE; gd++)
    begin : g_deg
        for (genvar gk = 0; gk < gd; gk++)
        begin : g_root
            localparam int IDX = gd * (gd - 1) / 2 + gk;
            assign root_tab[IDX] = nra_pkg::make_root(gk, gd, FRAC_BITS);
        end
    end

    // saturate a wide signed value to +-(2^31-1)
    function automatic logic signed [31:0] sat32(logic signed [66:0] v);
        if (v > SAT_HI)
            return nra_pkg::SAT_MAX;
        else if (v < -SAT_HI)
            return -nra_pkg::SAT_MAX;
        else
            return v[31:0];
    endfunction

    // round to nearest at FRAC_BITS, then saturate
    function automatic logic signed [31:0] rnd_sat(logic signed [66:0] v);
        logic signed [66:0] t;
        t = (v + HALF_LSB) >>> FRAC_BITS;
        return sat32(t);
    endfunction

    // clamp a difference to +-2^31 before squaring
    function automatic logic signed [32:0] clamp_sq(logic signed [33:0] v);
        if (v > 34'sd2147483648)
            return 33'sd2147483648;
        else if (v < -34'sd2147483648)
            return -33'sd2147483648;
        else
            return v[32:0];
    endfunction

    function automatic logic signed [32:0] ext33(logic signed [31:0] v);
        return {v[31], v};
    endfunction

    function automatic logic signed [66:0] ext67(logic signed [31:0] v);
        return {{35{v[31]}}, v};
    endfunction

    nra_cfg u_cfg
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    logic signed [32:0] mac_a;
    logic signed [32:0] mac_b;
    nra_pkg::mac_op_t   mac_op;
    logic signed [65:0] mac_prod;
    logic signed [66:0] mac_acc;

    nra_mac u_mac
    (
        .clk   (clk),
        .rst_n (rst_n),
        .op_a  (mac_a),
        .op_b  (mac_b),
        .op    (mac_op),
        .prod  (mac_prod),
        .acc   (mac_acc)
    );

    logic               div_start;
    logic signed [63:0] div_num;
    logic               div_done;
    logic signed [31:0] div_quo;

    logic [5:0]         state_reg, state_next;
    logic [IW-1:0]      it_reg, it_next;
    logic [IW-1:0]      cap_reg, cap_next;
    logic [DW-1:0]      d_reg, d_next;
    logic [DW-1:0]      k_reg, k_next;
    logic [DW-1:0]      j_reg, j_next;
    logic [RW-1:0]      base_reg, base_next;
    logic signed [31:0] zr_reg, zr_next;
    logic signed [31:0] zi_reg, zi_next;
    logic signed [31:0] pr_reg, pr_next;
    logic signed [31:0] pi_reg, pi_next;
    logic signed [31:0] tr_reg, tr_next;
    logic signed [31:0] ti_reg, ti_next;
    logic signed [31:0] nr_reg, nr_next;
    logic signed [31:0] ni_reg, ni_next;
    logic signed [31:0] dr_reg, dr_next;
    logic signed [31:0] di_reg, di_next;
    logic signed [31:0] qr_reg, qr_next;
    logic [63:0]        den_reg, den_next;
    logic signed [63:0] numr_reg, numr_next;
    logic signed [63:0] numi_reg, numi_next;
    logic [1:0]         res_out_reg, res_out_next;
    logic [3:0]         res_root_reg, res_root_next;
    logic [6:0]         res_cnt_reg, res_cnt_next;
    logic               out_valid_reg, out_valid_next;
    logic [1:0]         out_outcome_reg, out_outcome_next;
    logic [3:0]         out_root_reg, out_root_next;
    logic [6:0]         out_cnt_reg, out_cnt_next;

    // with a zero derivative the quotient takes the sign of z^d - 1
    assign div_start = (state_reg == S_DVR) || (state_reg == S_DVI);
    assign div_num   = (state_reg == S_DVR)
                       ? ((den_reg == 64'd0) ? {{32{nr_reg[31]}}, nr_reg} : numr_reg)
                       : ((den_reg == 64'd0) ? {{32{ni_reg[31]}}, ni_reg} : numi_reg);

    nra_div #(.FRAC_BITS(FRAC_BITS)) u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (den_reg),
        .done  (div_done),
        .quo   (div_quo)
    );

    // current root, escape test, effective settings
    logic [63:0]        root_ent;
    logic signed [31:0] rr;
    logic signed [31:0] ri;
    logic [CMP_W-1:0]   lim;
    logic [CMP_W-1:0]   abs_zr;
    logic [CMP_W-1:0]   abs_zi;
    logic [DW-1:0]      deg_eff;
    logic [IW-1:0]      cap_eff;
    logic signed [32:0] zr_abs33;
    logic signed [32:0] zi_abs33;

    assign root_ent = root_tab[base_reg + RW'(k_reg)];
    assign rr       = root_ent[63:32];
    assign ri       = root_ent[31:0];
    assign lim      = CMP_W'(cfg.esc_limit) << FRAC_BITS;
    assign zr_abs33 = zr_reg[31] ? -ext33(zr_reg) : ext33(zr_reg);
    assign zi_abs33 = zi_reg[31] ? -ext33(zi_reg) : ext33(zi_reg);
    assign abs_zr   = CMP_W'($unsigned(zr_abs33));
    assign abs_zi   = CMP_W'($unsigned(zi_abs33));

    always_comb
    begin
        if (cfg.degree == 4'd0)
            deg_eff = DW'(1);
        else if ({1'b0, cfg.degree} > 5'(MAX_DEGREE))
            deg_eff = DW'(MAX_DEGREE);
        else
            deg_eff = DW'(cfg.degree);
        if ({2'b0, cfg.iter_cap} > 9'(MAX_ITER))
            cap_eff = IW'(MAX_ITER);
        else
            cap_eff = IW'(cfg.iter_cap);
    end

    assign item_in.ready              = (state_reg == S_IDLE);
    assign result_out.valid           = out_valid_reg;
    assign result_out.outcome         = out_outcome_reg;
    assign result_out.root_index      = out_root_reg;
    assign result_out.iteration_count = out_cnt_reg;

    // sequencer
    always_comb
    begin
        state_next    = state_reg;
        it_next       = it_reg;
        cap_next      = cap_reg;
        d_next        = d_reg;
        k_next        = k_reg;
        j_next        = j_reg;
        base_next     = base_reg;
        zr_next       = zr_reg;
        zi_next       = zi_reg;
        pr_next       = pr_reg;
        pi_next       = pi_reg;
        tr_next       = tr_reg;
        ti_next       = ti_reg;
        nr_next       = nr_reg;
        ni_next       = ni_reg;
        dr_next       = dr_reg;
        di_next       = di_reg;
        qr_next       = qr_reg;
        den_next      = den_reg;
        numr_next     = numr_reg;
        numi_next     = numi_reg;
        res_out_next  = res_out_reg;
        res_root_next = res_root_reg;
        res_cnt_next  = res_cnt_reg;
        mac_a         = 33'sd0;
        mac_b         = 33'sd0;
        mac_op        = nra_pkg::MAC_NONE;

        // result register drains independently
        out_valid_next   = out_valid_reg && !result_out.ready;
        out_outcome_next = out_outcome_reg;
        out_root_next    = out_root_reg;
        out_cnt_next     = out_cnt_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (item_in.valid)
                begin
                    zr_next    = item_in.start_real;
                    zi_next    = item_in.start_imag;
                    d_next     = deg_eff;
                    cap_next   = cap_eff;
                    base_next  = RW'(((2*DW)'(deg_eff) * (2*DW)'(deg_eff - DW'(1))) >> 1);
                    it_next    = '0;
                    state_next = S_CHK;
                end
            end
            S_CHK:
            begin
                if (it_reg >= cap_reg)
                begin
                    res_out_next  = nra_pkg::OUT_CAP_HIT;
                    res_root_next = 4'd0;
                    res_cnt_next  = 7'(cap_reg);
                    state_next    = S_FIN;
                end
                else
                begin
                    mac_a      = ext33(zr_reg);
                    mac_b      = ext33(zr_reg);
                    mac_op     = nra_pkg::MAC_LOAD;
                    state_next = S_NZ1;
                end
            end
            S_NZ1:
            begin
                mac_a      = ext33(zi_reg);
                mac_b      = ext33(zi_reg);
                mac_op     = nra_pkg::MAC_ADD;
                state_next = S_NZ2;
            end
            S_NZ2:
            begin
                state_next = S_NZ3;
            end
            S_NZ3:
            begin
                // near zero first, then escape
                if ($unsigned(mac_acc) <= THR)
                begin
                    res_out_next  = nra_pkg::OUT_NEAR_ZERO;
                    res_root_next = 4'd0;
                    res_cnt_next  = 7'(it_reg);
                    state_next    = S_FIN;
                end
                else if (abs_zr > lim || abs_zi > lim)
                begin
                    res_out_next  = nra_pkg::OUT_ESCAPED;
                    res_root_next = 4'd0;
                    res_cnt_next  = 7'(it_reg);
                    state_next    = S_FIN;
                end
                else
                begin
                    k_next     = '0;
                    state_next = S_CV0;
                end
            end
            S_CV0:
            begin
                mac_a      = clamp_sq({zr_reg[31], zr_reg[31], zr_reg} - {rr[31], rr[31], rr});
                mac_b      = mac_a;
                mac_op     = nra_pkg::MAC_LOAD;
                state_next = S_CV1;
            end
            S_CV1:
            begin
                mac_a      = clamp_sq({zi_reg[31], zi_reg[31], zi_reg} - {ri[31], ri[31], ri});
                mac_b      = mac_a;
                mac_op     = nra_pkg::MAC_ADD;
                state_next = S_CV2;
            end
            S_CV2:
            begin
                state_next = S_CV3;
            end
            S_CV3:
            begin
                // lowest root index wins
                if ($unsigned(mac_acc) <= THR)
                begin
                    res_out_next  = nra_pkg::OUT_CONVERGED;
                    res_root_next = 4'(k_reg);
                    res_cnt_next  = 7'(it_reg);
                    state_next    = S_FIN;
                end
                else if (k_reg == d_reg - DW'(1))
                begin
                    pr_next    = ONE_Q;
                    pi_next    = 32'sd0;
                    j_next     = DW'(1);
                    state_next = S_PW0;
                end
                else
                begin
                    k_next     = k_reg + DW'(1);
                    state_next = S_CV0;
                end
            end
            // complex product p * z
            S_PW0:
            begin
                mac_a      = ext33(pr_reg);
                mac_b      = ext33(zr_reg);
                mac_op     = nra_pkg::MAC_LOAD;
                state_next = S_PW1;
            end
            S_PW1:
            begin
                mac_a      = ext33(pi_reg);
                mac_b      = ext33(zi_reg);
                mac_op     = nra_pkg::MAC_SUB;
                state_next = S_PW2;
            end
            S_PW2:
            begin
                mac_a      = ext33(pr_reg);
                mac_b      = ext33(zi_reg);
                mac_op     = nra_pkg::MAC_LOAD;
                state_next = S_PW3;
            end
            S_PW3:
            begin
                tr_next    = rnd_sat(mac_acc);
                mac_a      = ext33(pi_reg);
                mac_b      = ext33(zr_reg);
                mac_op     = nra_pkg::MAC_ADD;
                state_next = S_PW4;
            end
            S_PW4:
            begin
                state_next = S_PW5;
            end
            S_PW5:
            begin
                ti_next = rnd_sat(mac_acc);
                if (j_reg < d_reg)
                begin
                    pr_next    = tr_reg;
                    pi_next    = rnd_sat(mac_acc);
                    j_next     = j_reg + DW'(1);
                    state_next = S_PW0;
                end
                else
                begin
                    state_next = S_DR0;
                end
            end
            // derivative d * z^(d-1) and numerator z^d - 1
            S_DR0:
            begin
                nr_next    = sat32(ext67(tr_reg) - ext67(ONE_Q));
                ni_next    = ti_reg;
                mac_a      = ext33(pr_reg);
                mac_b      = 33'(d_reg);
                state_next = S_DR1;
            end
            S_DR1:
            begin
                dr_next    = sat32({mac_prod[65], mac_prod});
                mac_a      = ext33(pi_reg);
                mac_b      = 33'(d_reg);
                state_next = S_DR2;
            end
            S_DR2:
            begin
                di_next    = sat32({mac_prod[65], mac_prod});
                state_next = S_DN0;
            end
            // denominator and both numerators of the quotient
            S_DN0:
            begin
                mac_a      = ext33(dr_reg);
                mac_b      = ext33(dr_reg);
                mac_op     = nra_pkg::MAC_LOAD;
                state_next = S_DN1;
            end
            S_DN1:
            begin
                mac_a      = ext33(di_reg);
                mac_b      = ext33(di_reg);
                mac_op     = nra_pkg::MAC_ADD;
                state_next = S_DN2;
            end
            S_DN2:
            begin
                state_next = S_DN3;
            end
            S_DN3:
            begin
                den_next   = mac_acc[63:0];
                mac_a      = ext33(nr_reg);
                mac_b      = ext33(dr_reg);
                mac_op     = nra_pkg::MAC_LOAD;
                state_next = S_DN4;
            end
            S_DN4:
            begin
                mac_a      = ext33(ni_reg);
                mac_b      = ext33(di_reg);
                mac_op     = nra_pkg::MAC_ADD;
                state_next = S_DN5;
            end
            S_DN5:
            begin
                mac_a      = ext33(ni_reg);
                mac_b      = ext33(dr_reg);
                mac_op     = nra_pkg::MAC_LOAD;
                state_next = S_DN6;
            end
            S_DN6:
            begin
                numr_next  = mac_acc[63:0];
                mac_a      = ext33(nr_reg);
                mac_b      = ext33(di_reg);
                mac_op     = nra_pkg::MAC_SUB;
                state_next = S_DN7;
            end
            S_DN7:
            begin
                state_next = S_DN8;
            end
            S_DN8:
            begin
                numi_next  = mac_acc[63:0];
                state_next = S_DVR;
            end
            S_DVR:
            begin
                state_next = S_DVRW;
            end
            S_DVRW:
            begin
                if (div_done)
                begin
                    qr_next    = div_quo;
                    state_next = S_DVI;
                end
            end
            S_DVI:
            begin
                state_next = S_DVIW;
            end
            S_DVIW:
            begin
                if (div_done)
                begin
                    zr_next    = sat32(ext67(zr_reg) - ext67(qr_reg));
                    zi_next    = sat32(ext67(zi_reg) - ext67(div_quo));
                    state_next = S_UPD;
                end
            end
            S_UPD:
            begin
                it_next    = it_reg + IW'(1);
                state_next = S_CHK;
            end
            S_FIN:
            begin
                if (!out_valid_reg || result_out.ready)
                begin
                    out_valid_next   = 1'b1;
                    out_outcome_next = res_out_reg;
                    out_root_next    = res_root_reg;
                    out_cnt_next     = res_cnt_reg;
                    state_next       = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        it_reg          <= it_next;
        cap_reg         <= cap_next;
        d_reg           <= d_next;
        k_reg           <= k_next;
        j_reg           <= j_next;
        base_reg        <= base_next;
        zr_reg          <= zr_next;
        zi_reg          <= zi_next;
        pr_reg          <= pr_next;
        pi_reg          <= pi_next;
        tr_reg          <= tr_next;
        ti_reg          <= ti_next;
        nr_reg          <= nr_next;
        ni_reg          <= ni_next;
        dr_reg          <= dr_next;
        di_reg          <= di_next;
        qr_reg          <= qr_next;
        den_reg         <= den_next;
        numr_reg        <= numr_next;
        numi_reg        <= numi_next;
        res_out_reg     <= res_out_next;
        res_root_reg    <= res_root_next;
        res_cnt_reg     <= res_cnt_next;
        out_outcome_reg <= out_outcome_next;
        out_root_reg    <= out_root_next;
        out_cnt_reg     <= out_cnt_next;
    end

endmodule

FILE: verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: testbench for newton_root_attractor
// Drives start points through the item channel and programs the registers
// over APB between phases. A scoreboard class predicts outcome, root index
// and step count of every accepted point and checks each result in order.
// ----------------------------------------------------------------------------
module tb_top;

    localparam logic [1:0] REG_UNUSED = 2'd3;
    localparam longint     SAT_LIM    = 64'sd2147483647;
    localparam int         FRAC       = 24;

    typedef struct {
        logic [1:0] outcome;
        logic [3:0] root_index;
        logic [6:0] iteration_count;
    } attractor_result_t;

    // ------------------------------------------------------------------------
    // predictor and expected results
    // ------------------------------------------------------------------------
    class attractor_scoreboard;
        longint            root_re[55];
        longint            root_im[55];
        logic [3:0]        degree;
        logic [6:0]        esc_limit;
        logic [6:0]        iter_cap;
        attractor_result_t pending_results[$];
        int                errors;

        function new();
            for (int d = 1; d <= 10; d++)
                for (int k = 0; k < d; k++)
                    unit_root(k, d, d * (d - 1) / 2 + k);
            degree    = nra_pkg::DEGREE_RST;
            esc_limit = nra_pkg::ESC_LIM_RST;
            iter_cap  = nra_pkg::ITER_CAP_RST;
            errors    = 0;
        endfunction

        // cos/sin of the reduced angle by series, then quadrant rotation
        function void unit_root(int k, int d, int slot);
            longint unsigned ang;
            longint unsigned term;
            longint          c;
            longint          s;
            int              quad;
            int              rem;
            quad = (4 * k) / d;
            rem  = (4 * k) % d;
            ang  = (64'd1686629713 * rem + d / 2) / d;
            term = 64'd1073741824;
            c    = 0;
            s    = 0;
            for (int n = 0; n < 24; n++)
            begin
                case (n % 4)
                    0: c += term;
                    1: s += term;
                    2: c -= term;
                    default: s -= term;
                endcase
                term = ((term * ang) >> 30) / (n + 1);
            end
            c = q30_to_frac(c);
            s = q30_to_frac(s);
            case (quad % 4)
                0:
                begin
                    root_re[slot] = c;
                    root_im[slot] = s;
                end
                1:
                begin
                    root_re[slot] = -s;
                    root_im[slot] = c;
                end
                2:
                begin
                    root_re[slot] = -c;
                    root_im[slot] = -s;
                end
                default:
                begin
                    root_re[slot] = s;
                    root_im[slot] = -c;
                end
            endcase
        endfunction

        function longint q30_to_frac(longint v);
            if (v < 0)
                v = 0;
            if (v > 64'sd1073741824)
                v = 64'sd1073741824;
            return (v + 32) >>> 6;
        endfunction

        function int eff_degree();
            if (degree == 0)
                return 1;
            if (degree > 10)
                return 10;
            return degree;
        endfunction

        function longint sat(longint v);
            if (v > SAT_LIM)
                return SAT_LIM;
            if (v < -SAT_LIM)
                return -SAT_LIM;
            return v;
        endfunction

        function longint round_frac(longint p);
            return (p + (64'sd1 << (FRAC - 1))) >>> FRAC;
        endfunction

        function longint unsigned mag_sq(longint v);
            longint unsigned a;
            if (v < 0)
                v = -v;
            a = v;
            if (a > 64'd2147483648)
                a = 64'd2147483648;
            return a * a;
        endfunction

        // floor(u * 2^F / den), saturated
        function longint frac_quot(longint unsigned u, longint unsigned den);
            longint unsigned ip;
            longint unsigned rem;
            longint unsigned q;
            ip  = u / den;
            rem = u % den;
            if (ip > (64'd2147483647 >> FRAC))
                return SAT_LIM;
            q = ip;
            for (int b = 0; b < FRAC; b++)
            begin
                rem = rem << 1;
                q   = q << 1;
                if (rem >= den)
                begin
                    rem  = rem - den;
                    q[0] = 1'b1;
                end
            end
            return q;
        endfunction

        function longint signed_quot(longint s, longint unsigned den);
            if (s < 0)
                return -frac_quot(-s, den);
            return frac_quot(s, den);
        endfunction

        function attractor_result_t predict_attractor(logic signed [31:0] sr,
                                                      logic signed [31:0] si);
            attractor_result_t res;
            longint            zr;
            longint            zi;
            longint            pr;
            longint            pi;
            longint            tr;
            longint            ti;
            longint            nr;
            longint            ni;
            longint            dr;
            longint            di;
            longint            qr;
            longint            qi;
            longint            lim;
            longint unsigned   thr;
            longint unsigned   den;
            int                d;
            int                cap;
            int                base;
            bit                hit;
            zr  = sr;
            zi  = si;
            d   = eff_degree();
            cap = iter_cap;
            base = d * (d - 1) / 2;
            thr = (64'd1 << (2 * FRAC)) / 1000000;
            lim = longint'(esc_limit) << FRAC;
            res.outcome         = nra_pkg::OUT_CAP_HIT;
            res.root_index      = 0;
            res.iteration_count = cap;
            for (int it = 0; it < cap; it++)
            begin
                hit = 0;
                if (mag_sq(zr) + mag_sq(zi) <= thr)
                begin
                    res.outcome         = nra_pkg::OUT_NEAR_ZERO;
                    res.iteration_count = it;
                    break;
                end
                if (zr > lim || -zr > lim || zi > lim || -zi > lim)
                begin
                    res.outcome         = nra_pkg::OUT_ESCAPED;
                    res.iteration_count = it;
                    break;
                end
                for (int k = 0; k < d; k++)
                    if (!hit && mag_sq(zr - root_re[base + k])
                                + mag_sq(zi - root_im[base + k]) <= thr)
                    begin
                        hit = 1;
                        res.root_index = k;
                    end
                if (hit)
                begin
                    res.outcome         = nra_pkg::OUT_CONVERGED;
                    res.iteration_count = it;
                    break;
                end
                // z^(d-1) and z^d by repeated complex products
                pr = 64'sd1 << FRAC;
                pi = 0;
                for (int k = 1; k <= d; k++)
                begin
                    tr = sat(round_frac(pr * zr - pi * zi));
                    ti = sat(round_frac(pr * zi + pi * zr));
                    if (k < d)
                    begin
                        pr = tr;
                        pi = ti;
                    end
                end
                nr  = sat(tr - (64'sd1 << FRAC));
                ni  = ti;
                dr  = sat(pr * d);
                di  = sat(pi * d);
                den = dr * dr + di * di;
                if (den == 0)
                begin
                    qr = nr > 0 ? SAT_LIM : (nr < 0 ? -SAT_LIM : 0);
                    qi = ni > 0 ? SAT_LIM : (ni < 0 ? -SAT_LIM : 0);
                end
                else
                begin
                    qr = signed_quot(nr * dr + ni * di, den);
                    qi = signed_quot(ni * dr - nr * di, den);
                end
                zr = sat(zr - qr);
                zi = sat(zi - qi);
            end
            return res;
        endfunction

        function void note_point(logic signed [31:0] sr, logic signed [31:0] si);
            pending_results.push_back(predict_attractor(sr, si));
        endfunction

        function void check_result(logic [1:0] oc, logic [3:0] ri, logic [6:0] ic);
            attractor_result_t exp_res;
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result outcome=%0d root=%0d count=%0d",
                         $realtime, oc, ri, ic);
                errors++;
                return;
            end
            exp_res = pending_results.pop_front();
            if (oc !== exp_res.outcome)
            begin
                $display("%0t: outcome expected %0d actual %0d",
                         $realtime, exp_res.outcome, oc);
                errors++;
            end
            if (ri !== exp_res.root_index)
            begin
                $display("%0t: root_index expected %0d actual %0d",
                         $realtime, exp_res.root_index, ri);
                errors++;
            end
            if (ic !== exp_res.iteration_count)
            begin
                $display("%0t: iteration_count expected %0d actual %0d",
                         $realtime, exp_res.iteration_count, ic);
                errors++;
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    nra_in_if  item_in ();
    nra_out_if result_out ();

    newton_root_attractor uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .item_in    (item_in.sink),
        .result_out (result_out.source)
    );

    attractor_scoreboard sb = new();
    bit                  idle_on;
    int                  ready_hold;

    // clock
    initial clk = 1'b0;
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // result side: check accepted items, stall in random bursts while idling is on
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_out.ready <= 1'b0;
            ready_hold = 0;
        end
        else
        begin
            if (result_out.valid && result_out.ready)
                sb.check_result(result_out.outcome, result_out.root_index,
                                result_out.iteration_count);
            if (ready_hold > 0)
            begin
                result_out.ready <= 1'b0;
                ready_hold--;
            end
            else if (idle_on && $urandom_range(0, 7) == 0)
            begin
                result_out.ready <= 1'b0;
                ready_hold = $urandom_range(0, 5);
            end
            else
                result_out.ready <= 1'b1;
        end
    end

    // register write: setup then access cycle
    task automatic reg_write(logic [1:0] idx, logic [31:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            nra_pkg::REG_DEGREE:   sb.degree    = value[3:0];
            nra_pkg::REG_ESC_LIM:  sb.esc_limit = value[6:0];
            nra_pkg::REG_ITER_CAP: sb.iter_cap  = value[6:0];
            default: ;
        endcase
    endtask

    // stop offering items and let every accepted item drain
    task automatic wait_idle();
        item_in.valid <= 1'b0;
        while (sb.pending_results.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic set_config(int deg, int esc, int cap);
        wait_idle();
        reg_write(nra_pkg::REG_DEGREE, deg);
        reg_write(nra_pkg::REG_ESC_LIM, esc);
        reg_write(nra_pkg::REG_ITER_CAP, cap);
    endtask

    // offer one point, optionally after an idle burst, until accepted
    task automatic send_point(logic signed [31:0] sr, logic signed [31:0] si);
        if (idle_on && $urandom_range(0, 5) == 0)
        begin
            item_in.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        item_in.valid      <= 1'b1;
        item_in.start_real <= sr;
        item_in.start_imag <= si;
        @(posedge clk);
        while (!item_in.ready)
            @(posedge clk);
        sb.note_point(sr, si);
    endtask

    // mostly near a root or inside the basin region, some full range
    task automatic send_random(int n);
        int          sel;
        int          base;
        int          d;
        longint      re;
        longint      im;
        for (int i = 0; i < n; i++)
        begin
            sel  = $urandom_range(0, 99);
            d    = sb.eff_degree();
            base = d * (d - 1) / 2 + $urandom_range(0, d - 1);
            if (sel < 35)
            begin
                re = sb.root_re[base] + $urandom_range(0, 1 << 21) - (1 << 20);
                im = sb.root_im[base] + $urandom_range(0, 1 << 21) - (1 << 20);
            end
            else if (sel < 65)
            begin
                re = longint'($urandom_range(0, 1 << 26)) - (1 << 25);
                im = longint'($urandom_range(0, 1 << 26)) - (1 << 25);
            end
            else if (sel < 85)
            begin
                re = longint'($urandom_range(0, 1 << 29)) - (1 << 28);
                im = longint'($urandom_range(0, 1 << 29)) - (1 << 28);
            end
            else
            begin
                re = $signed($urandom);
                im = $signed($urandom);
            end
            send_point(re[31:0], im[31:0]);
        end
    endtask

    // stimulus
    initial
    begin
        rst_n              = 1'b0;
        psel               = 1'b0;
        penable            = 1'b0;
        pwrite             = 1'b0;
        paddr              = '0;
        pwdata             = '0;
        item_in.valid      = 1'b0;
        item_in.start_real = '0;
        item_in.start_imag = '0;
        idle_on            = 1'b1;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // reset settings: extremes, near-zero edge, roots, escape edge
        send_point(0, 0);
        send_point(32'sh7fffffff, 32'sh7fffffff);
        send_point(32'sh80000000, 32'sh80000000);
        send_point(0, 32'sh80000000);
        send_point(16777, 0);
        send_point(16778, 0);
        send_point(32'sd16777216, 0);
        send_point(sb.root_re[4], sb.root_im[4]);
        send_point(sb.root_re[5], sb.root_im[5]);
        send_point(32'sh7e000000, 0);
        send_point(32'sd2130706432, 32'sd1000);
        send_point(32'sd2130706433, 0);
        send_point(0, 32'sd16777216);
        send_point(-32'sd16777216, 32'sd5000000);

        // degree 10: derivative rounds to zero
        set_config(10, 127, 30);
        send_point(18455, 0);
        send_point(-18455, 18455);
        send_random(35);
        wait_idle();
        reg_write(REG_UNUSED, 32'hffffffff);

        set_config(1, 1, 1);
        send_random(30);
        set_config(0, 0, 6);
        send_random(30);
        set_config(15, 4, 0);
        send_random(25);
        set_config(2, 127, 40);
        send_random(40);
        set_config(5, 10, 16);
        send_random(40);
        set_config(7, 127, 25);
        send_random(40);

        // closing stretch without idling
        set_config($urandom_range(1, 10), 127, 12);
        idle_on = 1'b0;
        send_random(50);

        wait_idle();
        repeat (50) @(posedge clk);
        if (sb.errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    // run limit
    initial
    begin
        #60000000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule
